// ===== design/fpc_pkg.sv =====
// shared types, codes and constants for the fixed-point format converter
package fpc_pkg;

  localparam int MaxWidth = 32;
  localparam int ExpWidth = 7;
  localparam int CfgIndexWidth = 3;
  // wide enough for any exponent difference, float exponents included
  localparam int DeltaWidth = 10;

  // binary32 layout
  localparam int FltFracWidth = 23;
  localparam int FltExpWidth = 8;
  localparam int FltBias = 127;
  localparam int FltSubnormExp = 1 - FltBias - FltFracWidth;

  typedef enum logic [1:0] {
    KIND_UFIX  = 2'd0,
    KIND_SFIX  = 2'd1,
    KIND_INT   = 2'd2,
    KIND_FLOAT = 2'd3
  } src_kind_t;

  typedef enum logic [1:0] {
    RND_NEAREST_EVEN = 2'd0,
    RND_TO_ZERO      = 2'd1,
    RND_TO_PLUS      = 2'd2,
    RND_TO_MINUS     = 2'd3
  } round_mode_t;

  localparam logic [1:0] WCODE_8 = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;
  localparam logic [1:0] WCODE_32 = 2'd2;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_SOURCE_KIND       = 3'd0,
    REG_SOURCE_WIDTH_CODE = 3'd1,
    REG_SOURCE_EXPONENT   = 3'd2,
    REG_DEST_WIDTH_CODE   = 3'd3,
    REG_DEST_EXPONENT     = 3'd4,
    REG_DEST_SIGNED       = 3'd5,
    REG_ROUNDING_MODE     = 3'd6,
    REG_SATURATE          = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    src_kind_t                  source_kind;
    logic [1:0]                 source_width_code;
    logic signed [ExpWidth-1:0] source_exponent;
    logic [1:0]                 dest_width_code;
    logic signed [ExpWidth-1:0] dest_exponent;
    logic                       dest_signed;
    round_mode_t                rounding_mode;
    logic                       saturate;
  } cfg_t;

  // source reduced to sign, magnitude and power-of-two exponent
  typedef struct packed {
    logic                         zero;
    logic                         neg;
    logic [MaxWidth-1:0]          mag;
    logic signed [DeltaWidth-1:0] exponent;
  } unpk_t;

endpackage

// ===== design/fpc_cfg_regs.sv =====
// configuration register file
module fpc_cfg_regs
  import fpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [ExpWidth-1:0]      cfg_wr_data,
  output cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_kind       <= KIND_UFIX;
      cfg.source_width_code <= WCODE_32;
      cfg.source_exponent   <= '0;
      cfg.dest_width_code   <= WCODE_32;
      cfg.dest_exponent     <= '0;
      cfg.dest_signed       <= 1'b1;
      cfg.rounding_mode     <= RND_NEAREST_EVEN;
      cfg.saturate          <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_KIND:       cfg.source_kind <= src_kind_t'(cfg_wr_data[1:0]);
        REG_SOURCE_WIDTH_CODE: cfg.source_width_code <= cfg_wr_data[1:0];
        REG_SOURCE_EXPONENT:   cfg.source_exponent <= $signed(cfg_wr_data);
        REG_DEST_WIDTH_CODE:   cfg.dest_width_code <= cfg_wr_data[1:0];
        REG_DEST_EXPONENT:     cfg.dest_exponent <= $signed(cfg_wr_data);
        REG_DEST_SIGNED:       cfg.dest_signed <= cfg_wr_data[0];
        REG_ROUNDING_MODE:     cfg.rounding_mode <= round_mode_t'(cfg_wr_data[1:0]);
        REG_SATURATE:          cfg.saturate <= cfg_wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== design/fpc_unpack.sv =====
// splits a source word into sign, magnitude and exponent
module fpc_unpack
  import fpc_pkg::*;
(
  input  cfg_t                cfg,
  input  logic [MaxWidth-1:0] source_value,
  output unpk_t               unpk
);

  logic [MaxWidth-1:0]        smask;
  logic                       smsb;
  logic [MaxWidth-1:0]        v;
  logic [FltExpWidth-1:0]     fe;
  logic [FltFracWidth-1:0]    fr;
  logic signed [DeltaWidth-1:0] fix_exp;

  always_comb begin
    case (cfg.source_width_code)
      WCODE_8: begin
        smask = MaxWidth'(8'hFF);
        smsb  = source_value[7];
      end
      WCODE_16: begin
        smask = MaxWidth'(16'hFFFF);
        smsb  = source_value[15];
      end
      default: begin
        smask = '1;
        smsb  = source_value[MaxWidth-1];
      end
    endcase
    v  = source_value & smask;
    fe = source_value[FltFracWidth +: FltExpWidth];
    fr = source_value[FltFracWidth-1:0];
    fix_exp = DeltaWidth'(cfg.source_exponent);

    unpk.zero     = 1'b0;
    unpk.neg      = 1'b0;
    unpk.mag      = v;
    unpk.exponent = fix_exp;
    case (cfg.source_kind)
      KIND_UFIX: ;
      KIND_SFIX, KIND_INT: begin
        unpk.neg = smsb;
        if (smsb) begin
          unpk.mag = (~v + MaxWidth'(1)) & smask;
        end
        if (cfg.source_kind == KIND_INT) begin
          unpk.exponent = '0;
        end
      end
      default: begin
        unpk.zero = (fe == '0) && (fr == '0);
        unpk.neg  = source_value[MaxWidth-1];
        unpk.mag  = MaxWidth'({fe != '0, fr});
        // subnormals share the smallest normal exponent
        if (fe == '0) begin
          unpk.exponent = DeltaWidth'(FltSubnormExp);
        end else begin
          unpk.exponent = $signed(DeltaWidth'(fe)) - DeltaWidth'(FltBias + FltFracWidth);
        end
      end
    endcase
  end

endmodule

// ===== design/fpc_rescale.sv =====
// shifts the magnitude to the destination exponent, rounds, clamps when saturating and signs it
module fpc_rescale
  import fpc_pkg::*;
(
  input  cfg_t                cfg,
  input  unpk_t               unpk,
  output logic [MaxWidth-1:0] result_value,
  output logic                sign_error
);

  logic [MaxWidth-1:0]          dmask;
  logic [MaxWidth-1:0]          half_range;
  logic [MaxWidth-1:0]          maxmag;
  logic signed [DeltaWidth-1:0] delta;
  logic [DeltaWidth-1:0]        lsh;
  logic                         lbig;
  logic [2*MaxWidth-1:0]        shl;
  logic                         l_over;
  logic                         far;
  logic [2*MaxWidth-1:0]        ext;
  logic [MaxWidth-1:0]          q0;
  logic [MaxWidth-1:0]          rb;
  logic                         sticky;
  logic                         inexact;
  logic                         up;
  logic [MaxWidth:0]            q_rnd;
  logic [MaxWidth-1:0]          q;
  logic                         over;
  logic [MaxWidth-1:0]          qm;

  always_comb begin
    case (cfg.dest_width_code)
      WCODE_8: begin
        dmask      = MaxWidth'(8'hFF);
        half_range = MaxWidth'(8'h80);
      end
      WCODE_16: begin
        dmask      = MaxWidth'(16'hFFFF);
        half_range = MaxWidth'(16'h8000);
      end
      default: begin
        dmask      = '1;
        half_range = {1'b1, {(MaxWidth-1){1'b0}}};
      end
    endcase
    if (!cfg.dest_signed) begin
      maxmag = dmask;
    end else if (unpk.neg) begin
      maxmag = half_range;
    end else begin
      maxmag = half_range - MaxWidth'(1);
    end

    delta = DeltaWidth'(cfg.dest_exponent) - unpk.exponent;

    // left shift: any nonzero magnitude shifted by a full word or more overflows
    lsh    = DeltaWidth'(-delta);
    lbig   = lsh >= DeltaWidth'(MaxWidth);
    shl    = (2*MaxWidth)'(unpk.mag) << lsh[$clog2(MaxWidth)-1:0];
    l_over = (unpk.mag != '0) && (lbig || shl > (2*MaxWidth)'(maxmag));

    // right shift: remainder kept left-aligned below the quotient
    far = delta > DeltaWidth'(MaxWidth);
    ext = {unpk.mag, {MaxWidth{1'b0}}} >> delta[$clog2(MaxWidth):0];
    q0  = far ? '0 : ext[2*MaxWidth-1:MaxWidth];
    rb  = far ? '0 : ext[MaxWidth-1:0];
    sticky  = far && (unpk.mag != '0);
    inexact = (rb != '0) || sticky;
    case (cfg.rounding_mode)
      RND_NEAREST_EVEN: up = rb[MaxWidth-1] && ((rb[MaxWidth-2:0] != '0) || sticky || q0[0]);
      RND_TO_PLUS:      up = !unpk.neg && inexact;
      RND_TO_MINUS:     up = unpk.neg && inexact;
      default:          up = 1'b0;
    endcase
    q_rnd = (MaxWidth+1)'(q0) + (MaxWidth+1)'(up);

    if (delta < 0) begin
      q    = lbig ? '0 : shl[MaxWidth-1:0];
      over = l_over;
    end else begin
      q    = q_rnd[MaxWidth-1:0];
      over = q_rnd > (MaxWidth+1)'(maxmag);
    end
    if (over && cfg.saturate) begin
      q = maxmag;
    end
    qm = q & dmask;
    if (unpk.neg) begin
      qm = (~qm + MaxWidth'(1)) & dmask;
    end

    sign_error = unpk.neg && !cfg.dest_signed && !unpk.zero;
    result_value = (unpk.zero || sign_error) ? '0 : qm;
  end

endmodule

// ===== design/fixed_point_format_converter.sv =====
// Fixed-point format converter. Each beat on s_tdata is a 32-bit source word
// (fixed point, integer or binary32 float, per the configuration registers)
// and yields one beat on m_tdata/m_tuser holding the rescaled, rounded and
// optionally saturated result. A beat is taken every clock cycle unless m_tready
// back-pressure fills both registers: the input register for the source beat and
// the result register, driving m_tvalid, after the combinational unpack, barrel
// shift, round and clamp logic. While a result waits for m_tready the input
// register can still take one more beat, after which s_tready stays low until
// the result register drains. The user must write configuration via cfg_wr_en,
// cfg_index, cfg_wr_data only while no beats are in flight; it is not enforced.
module fixed_point_format_converter
  import fpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [ExpWidth-1:0]      cfg_wr_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [MaxWidth-1:0]      s_tdata,   // source_value
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [MaxWidth-1:0]      m_tdata,   // result_value
  output logic                     m_tuser    // sign_error
);

  cfg_t                cfg;
  unpk_t               unpk;
  logic                in_valid;
  logic                in_valid_next;
  logic [MaxWidth-1:0] in_data;
  logic                out_valid_next;
  logic                out_free;
  logic [MaxWidth-1:0] result_value;
  logic                sign_error;

  fpc_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  fpc_unpack u_unpack (
    .cfg          (cfg),
    .source_value (in_data),
    .unpk         (unpk)
  );

  fpc_rescale u_rescale (
    .cfg          (cfg),
    .unpk         (unpk),
    .result_value (result_value),
    .sign_error   (sign_error)
  );

  // the result register can load when empty or being drained this cycle
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !in_valid || out_free;

  always_comb begin
    in_valid_next  = s_tready ? s_tvalid : in_valid;
    out_valid_next = out_free ? in_valid : m_tvalid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
      m_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_data <= s_tdata;
    end
    if (in_valid && out_free) begin
      m_tdata <= result_value;
      m_tuser <= sign_error;
    end
  end

endmodule

// ===== sim/tb_fixed_point_format_converter.sv =====
// testbench for the fixed-point format converter: directed and random beats checked against a predictor
module tb_fixed_point_format_converter;
  import fpc_pkg::*;

  localparam logic [1:0] WCODE_ALIAS = 2'd3;  // spare code, behaves as 32 bits
  localparam int ExpMin = -64;
  localparam int ExpMax = 63;
  localparam int RandomBeats = 1400;

  typedef struct packed {
    logic [MaxWidth-1:0] value;
    logic                sign_error;
  } conv_result_t;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_SELDOM,
    READY_STALLED
  } ready_mode_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [ExpWidth-1:0]      cfg_wr_data = '0;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [MaxWidth-1:0]      s_tdata = '0;  // source_value
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [MaxWidth-1:0]      m_tdata;       // result_value
  logic                     m_tuser;       // sign_error

  cfg_t         cur_cfg;
  conv_result_t awaited_conversions[$];
  int           errors = 0;
  int           burst_left = 0;
  int           beats_sent = 0;
  ready_mode_t  ready_mode = READY_ALWAYS;
  int           ready_left = 0;

  fixed_point_format_converter u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

  always #6 clk = ~clk;

  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int width_bits(input logic [1:0] code);
    if (code == WCODE_8) return 8;
    if (code == WCODE_16) return 16;
    return MaxWidth;
  endfunction

  function automatic conv_result_t predict_conversion(input cfg_t c, input logic [31:0] raw);
    conv_result_t res;
    int unsigned  sw, dw, s;
    logic [63:0]  smask, dmask, mag, q, rem, half, maxmag, v;
    logic         neg, ovf, up;
    int           sexp, delta;
    logic [7:0]   fexp;
    logic [22:0]  frac;
    res = '0;
    neg = 1'b0;
    mag = '0;
    sexp = 0;
    up = 1'b0;
    sw = width_bits(c.source_width_code);
    smask = (64'd1 << sw) - 64'd1;
    case (c.source_kind)
      KIND_UFIX: begin
        mag = raw & smask;
        sexp = int'(c.source_exponent);
      end
      KIND_SFIX, KIND_INT: begin
        v = raw & smask;
        if (v[sw-1]) begin
          neg = 1'b1;
          mag = (~v + 64'd1) & smask;
        end else begin
          mag = v;
        end
        sexp = (c.source_kind == KIND_SFIX) ? int'(c.source_exponent) : 0;
      end
      default: begin
        fexp = raw[30:23];
        frac = raw[22:0];
        if (fexp == 8'd0 && frac == 23'd0) return res;
        neg = raw[31];
        if (fexp == 8'd0) begin
          mag = 64'(frac);
          sexp = FltSubnormExp;
        end else begin
          mag = 64'({1'b1, frac});
          sexp = int'(fexp) - FltBias - FltFracWidth;
        end
      end
    endcase

    if (neg && !c.dest_signed) begin
      res.sign_error = 1'b1;
      return res;
    end

    dw = width_bits(c.dest_width_code);
    dmask = (64'd1 << dw) - 64'd1;
    if (!c.dest_signed) maxmag = dmask;
    else maxmag = neg ? (64'd1 << (dw - 1)) : (64'd1 << (dw - 1)) - 64'd1;

    delta = int'(c.dest_exponent) - sexp;
    if (delta < 0) begin
      s = -delta;
      q = (s >= 64) ? 64'd0 : (mag << s);
      ovf = (mag != 0) && (s >= 32 || q > maxmag);
    end else if (delta > 0) begin
      s = delta;
      if (s >= 64) begin
        q = '0;
        rem = mag;
      end else begin
        q = mag >> s;
        rem = mag & ((64'd1 << s) - 64'd1);
      end
      case (c.rounding_mode)
        RND_NEAREST_EVEN: begin
          if (s <= 63) begin
            half = 64'd1 << (s - 1);
            up = (rem > half) || (rem == half && q[0]);
          end
        end
        RND_TO_PLUS:  up = !neg && rem != 0;
        RND_TO_MINUS: up = neg && rem != 0;
        default:      up = 1'b0;
      endcase
      if (up) q = q + 64'd1;
      ovf = q > maxmag;
    end else begin
      q = mag;
      ovf = q > maxmag;
    end

    if (ovf && c.saturate) q = maxmag;
    q = q & dmask;
    if (neg) q = (64'd0 - q) & dmask;
    res.value = q[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    conv_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (awaited_conversions.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata, '0);
      end else begin
        want = awaited_conversions.pop_front();
        if (m_tdata !== want.value) report_mismatch("result_value", m_tdata, want.value);
        if (m_tuser !== want.sign_error)
          report_mismatch("sign_error", 32'(m_tuser), 32'(want.sign_error));
      end
    end
  end

  // receiver stalls in phases of its own
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 3));
      ready_left = (ready_mode == READY_STALLED) ? $urandom_range(1, 12) : $urandom_range(4, 60);
    end
    ready_left--;
    case (ready_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_MOSTLY: m_tready <= ($urandom_range(0, 9) < 7);
      READY_SELDOM: m_tready <= ($urandom_range(0, 9) < 3);
      default:      m_tready <= 1'b0;
    endcase
  end

  task automatic send_beat(input logic [MaxWidth-1:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 16);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    awaited_conversions.push_back(predict_conversion(cur_cfg, word));
    burst_left--;
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (awaited_conversions.size() != 0);
  endtask

  // writes every register, one per cycle; only called with nothing in flight
  task automatic apply_config(input cfg_t c);
    cfg_reg_t            idx;
    logic [ExpWidth-1:0] val;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_t'(i);
      case (idx)
        REG_SOURCE_KIND:       val = ExpWidth'(c.source_kind);
        REG_SOURCE_WIDTH_CODE: val = ExpWidth'(c.source_width_code);
        REG_SOURCE_EXPONENT:   val = c.source_exponent;
        REG_DEST_WIDTH_CODE:   val = ExpWidth'(c.dest_width_code);
        REG_DEST_EXPONENT:     val = c.dest_exponent;
        REG_DEST_SIGNED:       val = ExpWidth'(c.dest_signed);
        REG_ROUNDING_MODE:     val = ExpWidth'(c.rounding_mode);
        default:               val = ExpWidth'(c.saturate);
      endcase
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      cfg_wr_data <= val;
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic logic signed [ExpWidth-1:0] clamp_exponent(input int e);
    if (e < ExpMin) return ExpWidth'(ExpMin);
    if (e > ExpMax) return ExpWidth'(ExpMax);
    return ExpWidth'(e);
  endfunction

  function automatic int pick_exponent();
    if ($urandom_range(0, 9) < 3) return ($urandom_range(0, 1) != 0) ? ExpMax : ExpMin;
    return int'($urandom_range(0, 127)) + ExpMin;
  endfunction

  // clears the low k bits and sets bit k-1, so a right shift by k lands on a tie
  function automatic logic [31:0] make_tie(input logic [31:0] w, input int k);
    return (w & ~((32'd1 << k) - 32'd1)) | (32'd1 << (k - 1));
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    int   sexp_i, base;
    c.source_kind = src_kind_t'($urandom_range(0, 3));
    c.source_width_code = 2'($urandom_range(0, 3));
    c.dest_width_code = 2'($urandom_range(0, 3));
    c.dest_signed = 1'($urandom_range(0, 1));
    c.rounding_mode = round_mode_t'($urandom_range(0, 3));
    c.saturate = 1'($urandom_range(0, 1));
    sexp_i = pick_exponent();
    c.source_exponent = clamp_exponent(sexp_i);
    base = (c.source_kind == KIND_INT) ? 0 : sexp_i;
    // float scale is steered by the word generator instead
    if (c.source_kind == KIND_FLOAT || $urandom_range(0, 4) == 0)
      c.dest_exponent = clamp_exponent(pick_exponent());
    else
      c.dest_exponent = clamp_exponent(base + int'($urandom_range(0, 56)) - 28);
    return c;
  endfunction

  function automatic logic [31:0] random_source_word(input cfg_t c);
    logic [31:0] word, m;
    int          sel, fexp, delta, sw;
    word = $urandom();
    sel = $urandom_range(0, 99);
    if (c.source_kind == KIND_FLOAT) begin
      if (sel < 12) begin
        case ($urandom_range(0, 3))
          0:       word[30:0] = '0;
          1:       word[30:23] = '0;
          2:       word[30:0] = {8'hFF, 23'h0};
          default: word[30:23] = 8'hFF;
        endcase
      end else begin
        // exponent near the destination scale keeps shifts short
        delta = 36 - int'($urandom_range(0, 60));
        fexp = int'(c.dest_exponent) + FltBias + FltFracWidth - delta;
        if (fexp < 1) fexp = 1;
        if (fexp > 254) fexp = 254;
        word[30:23] = fexp[7:0];
        delta = int'(c.dest_exponent) - (fexp - FltBias - FltFracWidth);
        if (sel < 40 && delta >= 1 && delta <= FltFracWidth) word = make_tie(word, delta);
      end
    end else begin
      sw = width_bits(c.source_width_code);
      m = (sw == 32) ? 32'hFFFF_FFFF : (32'd1 << sw) - 32'd1;
      if (sel < 15) begin
        word = word >> $urandom_range(0, 31);
      end else if (sel < 30) begin
        case ($urandom_range(0, 4))
          0:       word = word & ~m;
          1:       word = word | m;
          2:       word = (word & ~m) | (m >> 1);
          3:       word = (word & ~m) | ((m >> 1) + 32'd1);
          default: word = (word & ~m) | 32'd1;
        endcase
      end else if (sel < 50) begin
        delta = int'(c.dest_exponent)
                - ((c.source_kind == KIND_INT) ? 0 : int'(c.source_exponent));
        if (delta >= 1 && delta <= sw) word = make_tie(word, delta);
      end
    end
    return word;
  endfunction

  task automatic test_reset_values();
    logic [31:0] words[4] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000};
    foreach (words[i]) send_beat(words[i]);
    drain_results();
  endtask

  task automatic test_float_specials();
    logic [31:0] words[11] = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3F80_0000,
                               32'h4020_0000, 32'h4060_0000, 32'hBFC0_0000, 32'h7F80_0000,
                               32'hFF80_0000, 32'h7FC0_0000, 32'h807F_FFFF};
    // width code is ignored for floats
    apply_config('{source_kind: KIND_FLOAT, source_width_code: WCODE_8, source_exponent: '0,
                   dest_width_code: WCODE_32, dest_exponent: '0, dest_signed: 1'b1,
                   rounding_mode: RND_NEAREST_EVEN, saturate: 1'b1});
    foreach (words[i]) send_beat(words[i]);
    drain_results();
  endtask

  task automatic test_sign_error();
    logic [31:0] words[4] = '{32'h0000_0080, 32'h0000_007F, 32'hFFFF_FF01, 32'h0000_0000};
    apply_config('{source_kind: KIND_SFIX, source_width_code: WCODE_8,
                   source_exponent: 7'(ExpMax), dest_width_code: WCODE_ALIAS,
                   dest_exponent: 7'sd40, dest_signed: 1'b0, rounding_mode: RND_TO_PLUS,
                   saturate: 1'b1});
    foreach (words[i]) send_beat(words[i]);
    drain_results();
  endtask

  task automatic test_integer_source();
    logic [31:0] words[4] = '{32'h0000_8000, 32'h0000_7FFF, 32'h0000_FFF9, 32'h0000_0009};
    // source exponent must be ignored for an integer source
    apply_config('{source_kind: KIND_INT, source_width_code: WCODE_16,
                   source_exponent: 7'(ExpMin), dest_width_code: WCODE_8, dest_exponent: 7'sd3,
                   dest_signed: 1'b1, rounding_mode: RND_TO_MINUS, saturate: 1'b1});
    foreach (words[i]) send_beat(words[i]);
    drain_results();
  endtask

  task automatic test_truncation();
    logic [31:0] words[3] = '{32'h0000_FFFF, 32'h0000_0001, 32'h0000_0003};
    apply_config('{source_kind: KIND_UFIX, source_width_code: WCODE_16, source_exponent: '0,
                   dest_width_code: WCODE_16, dest_exponent: 7'sd1, dest_signed: 1'b0,
                   rounding_mode: RND_TO_ZERO, saturate: 1'b0});
    foreach (words[i]) send_beat(words[i]);
    drain_results();
  endtask

  task automatic test_random_configs();
    cfg_t c;
    int   batch;
    int   stop_at;
    stop_at = beats_sent + RandomBeats;
    while (beats_sent < stop_at) begin
      c = random_config();
      apply_config(c);
      batch = $urandom_range(10, 60);
      repeat (batch) send_beat(random_source_word(c));
      drain_results();
    end
  endtask

  initial begin
    cur_cfg = '{source_kind: KIND_UFIX, source_width_code: WCODE_32, source_exponent: '0,
                dest_width_code: WCODE_32, dest_exponent: '0, dest_signed: 1'b1,
                rounding_mode: RND_NEAREST_EVEN, saturate: 1'b0};
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_float_specials();
    test_sign_error();
    test_integer_source();
    test_truncation();
    test_random_configs();
    drain_results();
    repeat (4) @(negedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
